// File: rtl/lhm_pkg.sv
`timescale 1ns / 1ps
package lhm_pkg;

    localparam int NUM_LABELS_DEF = 16;
    localparam int COUNT_BITS_DEF = 24;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // z = 0.69 folded into fixed point: z^2/4 in Q.32, z^2/2 scaled by 1e4 in Q.16,
    // z scaled by 1e4, z^2 scaled by 1e4, and the scale 1e4 in Q.16.
    localparam logic [63:0] ZSQ4_Q32   = (64'd119025 << 32) / 64'd1000000;
    localparam logic [63:0] HALF_ZSQ_K = 64'd156008448;
    localparam logic [63:0] Z_K        = 64'd6900;
    localparam logic [63:0] ZSQ_K      = 64'd4761;
    localparam logic [63:0] SCALE_Q16  = 64'd655360000;
    localparam logic [63:0] N_SCALE    = 64'd10000;
    localparam logic [16:0] EST_MAX    = 17'd65536;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  label_id;
        logic [15:0] add_count;
    } req_t;

    typedef struct packed {
        logic [23:0] label_count;
        logic [23:0] total_rows;
        logic [4:0]  distinct_labels;
        logic        single_label;
        logic        majority_valid;
        logic [3:0]  majority_label;
        logic [23:0] majority_count;
        logic [23:0] minority_count;
        logic [16:0] error_estimate;
    } rsp_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EXEC,
        B_SUM,
        B_WAIT
    } back_state_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_MUL,
        E_PRE,
        E_DIV1,
        E_SQRT,
        E_NUM,
        E_SUM,
        E_DIV2
    } est_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } est_status_t;

endpackage

// File: rtl/lhm_front.sv
`timescale 1ns / 1ps
module lhm_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lhm_pkg::req_t req,
    output logic          q_valid,
    output lhm_pkg::req_t q_item,
    input  logic          q_pop
);

    lhm_pkg::req_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;

    assign req_stall = (cnt_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= req;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0)
        else $error("queue popped while empty");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 && !q_pop |=> cnt_reg == 2'd2)
        else $error("queue count lost an item while full");

endmodule

// File: rtl/lhm_est.sv
`timescale 1ns / 1ps
module lhm_est
#(
    parameter int COUNT_BITS = lhm_pkg::COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COUNT_BITS-1:0]   m,
    input  logic [COUNT_BITS-1:0]   n,
    output lhm_pkg::est_status_t    status,
    output logic [16:0]             est
);

    localparam int CB    = COUNT_BITS;
    localparam int YW    = 2 * CB;
    localparam int SHW   = CB + 30;
    localparam int DENW  = CB + 14;
    localparam int C1W   = $clog2(SHW);

    lhm_pkg::est_state_t state_reg, state_next;

    logic [CB-1:0]    m_reg, n_reg;
    logic [YW-1:0]    y_reg;
    logic [CB-1:0]    rem1_reg;
    logic [SHW-1:0]   sh1_reg;
    logic [63:0]      q1_reg;
    logic [63:0]      sx_reg;
    logic [33:0]      srem_reg;
    logic [31:0]      sroot_reg;
    logic [63:0]      pm_reg, ps_reg;
    logic [DENW-1:0]  den_reg;
    logic [DENW-1:0]  rem2_reg;
    logic [17:0]      sh2_reg;
    logic [17:0]      q2_reg;
    logic [C1W-1:0]   cnt_reg;

    logic [CB:0]      t1;
    logic             b1;
    logic [35:0]      sr2, st;
    logic             sb;
    logic [DENW:0]    t2;
    logic             b2;
    logic [63:0]      num;
    logic [63:0]      den_full;
    logic [63:0]      q1_new;
    logic [17:0]      q2_new;

    always_comb
    begin
        t1       = {rem1_reg, sh1_reg[SHW-1]};
        b1       = (t1 >= {1'b0, n_reg});
        q1_new   = {q1_reg[62:0], b1};
        sr2      = {srem_reg, sx_reg[63:62]};
        st       = {2'b00, sroot_reg, 2'b01};
        sb       = (sr2 >= st);
        t2       = {rem2_reg, sh2_reg[17]};
        b2       = (t2 >= {1'b0, den_reg});
        q2_new   = {q2_reg[16:0], b2};
        num      = pm_reg + ps_reg + lhm_pkg::HALF_ZSQ_K;
        den_full = 64'(n_reg) * lhm_pkg::N_SCALE + lhm_pkg::ZSQ_K;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lhm_pkg::E_IDLE: if (start) state_next = lhm_pkg::E_MUL;
            lhm_pkg::E_MUL:  state_next = lhm_pkg::E_PRE;
            lhm_pkg::E_PRE:  state_next = lhm_pkg::E_DIV1;
            lhm_pkg::E_DIV1: if (cnt_reg == '0) state_next = lhm_pkg::E_SQRT;
            lhm_pkg::E_SQRT: if (cnt_reg == '0) state_next = lhm_pkg::E_NUM;
            lhm_pkg::E_NUM:  state_next = lhm_pkg::E_SUM;
            lhm_pkg::E_SUM:  state_next = lhm_pkg::E_DIV2;
            lhm_pkg::E_DIV2: if (cnt_reg == '0) state_next = lhm_pkg::E_IDLE;
            default:         state_next = lhm_pkg::E_IDLE;
        endcase
    end

    always_comb
    begin
        status.busy = (state_reg != lhm_pkg::E_IDLE);
        status.done = (state_reg == lhm_pkg::E_DIV2) && (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lhm_pkg::E_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lhm_pkg::E_IDLE:
            begin
                m_reg <= m;
                n_reg <= n;
            end
            lhm_pkg::E_MUL:
            begin
                y_reg   <= YW'(m_reg) * YW'(n_reg - m_reg);
                den_reg <= den_full[DENW-1:0];
            end
            lhm_pkg::E_PRE:
            begin
                // The integer part of y/n does not exceed n/4, so the top bits already fit.
                rem1_reg <= y_reg[YW-3:CB-2];
                sh1_reg  <= {y_reg[CB-3:0], 32'd0};
                q1_reg   <= '0;
                cnt_reg  <= C1W'(SHW - 1);
            end
            lhm_pkg::E_DIV1:
            begin
                if (b1)
                begin
                    rem1_reg <= CB'(t1 - {1'b0, n_reg});
                end
                else
                begin
                    rem1_reg <= t1[CB-1:0];
                end
                sh1_reg <= {sh1_reg[SHW-2:0], 1'b0};
                q1_reg  <= q1_new;
                if (cnt_reg == '0)
                begin
                    sx_reg    <= q1_new + lhm_pkg::ZSQ4_Q32;
                    srem_reg  <= '0;
                    sroot_reg <= '0;
                    cnt_reg   <= C1W'(31);
                end
                else
                begin
                    cnt_reg <= cnt_reg - C1W'(1);
                end
            end
            lhm_pkg::E_SQRT:
            begin
                if (sb)
                begin
                    srem_reg  <= 34'(sr2 - st);
                    sroot_reg <= {sroot_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_reg  <= sr2[33:0];
                    sroot_reg <= {sroot_reg[30:0], 1'b0};
                end
                sx_reg  <= {sx_reg[61:0], 2'b00};
                cnt_reg <= cnt_reg - C1W'(1);
            end
            lhm_pkg::E_NUM:
            begin
                pm_reg <= 64'(m_reg) * lhm_pkg::SCALE_Q16;
                ps_reg <= 64'(sroot_reg) * lhm_pkg::Z_K;
            end
            lhm_pkg::E_SUM:
            begin
                // The quotient stays below 2^18, so num >> 18 is already below den.
                rem2_reg <= num[DENW+17:18];
                sh2_reg  <= num[17:0];
                q2_reg   <= '0;
                cnt_reg  <= C1W'(17);
            end
            lhm_pkg::E_DIV2:
            begin
                if (b2)
                begin
                    rem2_reg <= DENW'(t2 - {1'b0, den_reg});
                end
                else
                begin
                    rem2_reg <= t2[DENW-1:0];
                end
                sh2_reg <= {sh2_reg[16:0], 1'b0};
                q2_reg  <= q2_new;
                cnt_reg <= cnt_reg - C1W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // The estimate is taken in the cycle that done is high, from the last quotient bit.
    assign est = (q2_new > 18'(lhm_pkg::EST_MAX)) ? lhm_pkg::EST_MAX : q2_new[16:0];

endmodule

// File: rtl/lhm_back.sv
`timescale 1ns / 1ps
module lhm_back
#(
    parameter int NUM_LABELS = lhm_pkg::NUM_LABELS_DEF,
    parameter int COUNT_BITS = lhm_pkg::COUNT_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  lhm_pkg::req_t q_item,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lhm_pkg::rsp_t rsp
);

    localparam int CB = COUNT_BITS;
    localparam int IW = (NUM_LABELS > 2) ? $clog2(NUM_LABELS) : 1;
    localparam int DW = $clog2(NUM_LABELS + 1);
    localparam int SW = ((CB > 16) ? CB : 16) + 1;
    localparam logic [SW-1:0] CMAX = SW'({CB{1'b1}});

    lhm_pkg::back_state_t state_reg, state_next;

    logic [CB-1:0]         counts_reg [NUM_LABELS];
    logic [NUM_LABELS-1:0] present_reg;
    logic [CB-1:0]         total_reg;
    logic [IW-1:0]         best_label_reg;
    logic [CB-1:0]         best_count_reg;
    logic [DW-1:0]         dist_reg;
    lhm_pkg::req_t         item_reg;
    lhm_pkg::rsp_t         rsp_reg;
    logic                  out_full_reg;

    logic [7:0]    label_ext;
    logic [IW-1:0] idx;
    logic          in_range;
    logic [CB-1:0] old_count;
    logic [SW-1:0] lab_sum, tot_sum;
    logic [CB-1:0] new_count, new_total;
    logic          any;
    logic [CB-1:0] minority;
    logic          need_est;
    logic          est_start;
    lhm_pkg::est_status_t est_status;
    logic [16:0]   est_val;
    logic [31:0]   lc32, tot32, best32, min32;
    logic [8:0]    dist9;
    logic [7:0]    best8;

    assign label_ext = {4'd0, item_reg.label_id};
    assign idx       = label_ext[IW-1:0];
    assign in_range  = (9'(item_reg.label_id) < 9'(NUM_LABELS));

    always_comb
    begin
        old_count = present_reg[idx] ? counts_reg[idx] : '0;
        lab_sum   = SW'(old_count) + SW'(item_reg.add_count);
        tot_sum   = SW'(total_reg) + SW'(item_reg.add_count);
        new_count = (lab_sum > CMAX) ? CB'(CMAX) : lab_sum[CB-1:0];
        new_total = (tot_sum > CMAX) ? CB'(CMAX) : tot_sum[CB-1:0];
        any       = (dist_reg != '0);
        minority  = (any && total_reg >= best_count_reg) ? total_reg - best_count_reg : '0;
        need_est  = any && (total_reg != '0);
        lc32      = 32'((in_range && present_reg[idx]) ? counts_reg[idx] : '0);
        tot32     = 32'(total_reg);
        best32    = 32'(any ? best_count_reg : '0);
        min32     = 32'(minority);
        dist9     = 9'(dist_reg);
        best8     = 8'(any ? best_label_reg : '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lhm_pkg::B_IDLE: if (q_valid && !out_full_reg) state_next = lhm_pkg::B_EXEC;
            lhm_pkg::B_EXEC: state_next = lhm_pkg::B_SUM;
            lhm_pkg::B_SUM:  state_next = need_est ? lhm_pkg::B_WAIT : lhm_pkg::B_IDLE;
            lhm_pkg::B_WAIT: if (est_status.done) state_next = lhm_pkg::B_IDLE;
            default:         state_next = lhm_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == lhm_pkg::B_IDLE) && q_valid && !out_full_reg;
        est_start = (state_reg == lhm_pkg::B_SUM) && need_est;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lhm_pkg::B_IDLE;
            present_reg    <= '0;
            total_reg      <= '0;
            best_label_reg <= '0;
            best_count_reg <= '0;
            dist_reg       <= '0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lhm_pkg::B_EXEC)
            begin
                if (item_reg.opcode == lhm_pkg::OP_ADD && in_range)
                begin
                    present_reg[idx] <= 1'b1;
                    total_reg        <= new_total;
                    if (!present_reg[idx])
                    begin
                        dist_reg <= dist_reg + DW'(1);
                    end
                    // Counts only grow, so the majority can only move to this label.
                    if (dist_reg == '0 || idx == best_label_reg || new_count > best_count_reg
                        || (new_count == best_count_reg && idx < best_label_reg))
                    begin
                        best_label_reg <= idx;
                        best_count_reg <= new_count;
                    end
                end
                else if (item_reg.opcode == lhm_pkg::OP_CLEAR)
                begin
                    present_reg    <= '0;
                    total_reg      <= '0;
                    best_label_reg <= '0;
                    best_count_reg <= '0;
                    dist_reg       <= '0;
                end
            end
            if ((state_reg == lhm_pkg::B_SUM && !need_est)
                || (state_reg == lhm_pkg::B_WAIT && est_status.done))
            begin
                out_full_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == lhm_pkg::B_EXEC && item_reg.opcode == lhm_pkg::OP_ADD && in_range)
        begin
            counts_reg[idx] <= new_count;
        end
        if (state_reg == lhm_pkg::B_SUM)
        begin
            rsp_reg.label_count     <= lc32[23:0];
            rsp_reg.total_rows      <= tot32[23:0];
            rsp_reg.distinct_labels <= dist9[4:0];
            rsp_reg.single_label    <= (dist_reg == DW'(1));
            rsp_reg.majority_valid  <= any;
            rsp_reg.majority_label  <= best8[3:0];
            rsp_reg.majority_count  <= best32[23:0];
            rsp_reg.minority_count  <= min32[23:0];
            rsp_reg.error_estimate  <= '0;
        end
        if (state_reg == lhm_pkg::B_WAIT && est_status.done)
        begin
            rsp_reg.error_estimate <= est_val;
        end
    end

    assign rsp_valid = out_full_reg;
    assign rsp       = rsp_reg;

    lhm_est #(
        .COUNT_BITS (COUNT_BITS)
    ) u_est (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (est_start),
        .m      (minority),
        .n      (total_reg),
        .status (est_status),
        .est    (est_val)
    );

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        est_status.done |-> state_reg == lhm_pkg::B_WAIT)
        else $error("estimate finished with no item waiting for it");
    a_distinct_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (dist_reg == '0) == (present_reg == '0))
        else $error("distinct count disagrees with presence bits");
    a_best_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        best_count_reg <= total_reg)
        else $error("majority count exceeds total");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        est_start |-> !est_status.busy)
        else $error("estimate started while busy");

endmodule

// File: rtl/label_histogram_majority_top.sv
`timescale 1ns / 1ps
// Class-label statistics for one decision-tree node. Each request item carries an
// opcode (add, clear, query), a label id and an add amount; each produces exactly one
// response item with the addressed count, the saturating total, the number of distinct
// labels, the majority label and count (lowest id on ties), the minority count and the
// pessimistic error bound for z = 0.69 in unsigned Q1.16. A two-entry queue takes
// requests while the back end works. Once the back end takes an item, it executes it and
// registers the response fields; the response is valid once they are registered when the
// store is empty or the total is zero, and otherwise once the bit-serial estimate unit
// finishes: a long division of m(N-m)*2^32 by N, a 32-step square root and an 18-bit
// final division. The next item is taken in the cycle after the response leaves, so the
// back end works on one item at a time.
module label_histogram_majority_top
#(
    parameter int NUM_LABELS = lhm_pkg::NUM_LABELS_DEF,
    parameter int COUNT_BITS = lhm_pkg::COUNT_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lhm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lhm_pkg::rsp_t rsp
);

    logic          q_valid;
    logic          q_pop;
    lhm_pkg::req_t q_item;

    lhm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    lhm_back #(
        .NUM_LABELS (NUM_LABELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
